/* src/mi3_pkg.sv */
package mi3_pkg;

    // Element and arithmetic widths.
    localparam int EW       = 16;            // input element width
    localparam int FRAC_IN  = 12;            // fractional bits of an element
    localparam int FRAC_OUT = 16;            // fractional bits of a result
    localparam int PW       = 2 * EW;        // one element product
    localparam int AW       = PW + 1;        // cofactor, signed
    localparam int DPW      = AW + EW;       // cofactor times element
    localparam int DW       = DPW + 2;       // determinant, signed
    localparam int ADW      = DW - 1;        // determinant magnitude
    localparam int DNW      = ADW + 1;       // divisor, twice the magnitude
    localparam int SH       = 2 * FRAC_IN + FRAC_OUT - FRAC_IN + 1;
    localparam int NW       = AW + SH + 1;   // rounded dividend
    localparam int QW       = 32;            // quotient and result width
    localparam int NLANE    = 9;

    localparam logic [QW:0] POS_LIMIT = {2'b00, {(QW - 1){1'b1}}};
    localparam logic [QW:0] NEG_LIMIT = {2'b01, {(QW - 1){1'b0}}};

    typedef logic [3:0] idx_t;

    // Cofactor k is m[PA[k]]*m[PB[k]] - m[QA[k]]*m[QB[k]], row-major indexes.
    localparam idx_t PA [NLANE] = '{4'd4, 4'd2, 4'd1, 4'd5, 4'd0, 4'd2, 4'd3, 4'd6, 4'd0};
    localparam idx_t PB [NLANE] = '{4'd8, 4'd7, 4'd5, 4'd6, 4'd8, 4'd3, 4'd7, 4'd1, 4'd4};
    localparam idx_t QA [NLANE] = '{4'd5, 4'd1, 4'd2, 4'd3, 4'd2, 4'd0, 4'd4, 4'd0, 4'd1};
    localparam idx_t QB [NLANE] = '{4'd7, 4'd8, 4'd4, 4'd8, 4'd6, 4'd5, 4'd6, 4'd7, 4'd3};

    typedef struct packed {
        logic signed [EW-1:0] m00;
        logic signed [EW-1:0] m01;
        logic signed [EW-1:0] m02;
        logic signed [EW-1:0] m10;
        logic signed [EW-1:0] m11;
        logic signed [EW-1:0] m12;
        logic signed [EW-1:0] m20;
        logic signed [EW-1:0] m21;
        logic signed [EW-1:0] m22;
    } in_t;

    typedef struct packed {
        logic signed [QW-1:0] inv00;
        logic signed [QW-1:0] inv01;
        logic signed [QW-1:0] inv02;
        logic signed [QW-1:0] inv10;
        logic signed [QW-1:0] inv11;
        logic signed [QW-1:0] inv12;
        logic signed [QW-1:0] inv20;
        logic signed [QW-1:0] inv21;
        logic signed [QW-1:0] inv22;
        logic                 singular;
    } out_t;

endpackage

/* src/matrix_inverse_3x3_top.sv */
// 3x3 matrix inverse by the adjugate. Each transfer on the input channel
// carries one matrix of nine signed Q4.12 elements; each transfer on the
// output channel carries its inverse as nine signed Q16.16 elements,
// rounded to nearest with ties away from zero and saturated to 32 bits,
// plus a singular flag that is set (with all elements zero) when the
// determinant is exactly zero. Cofactors and determinant are exact. The
// block is a 40-stage pipeline: seven stages of input capture, products,
// cofactors, determinant and divider setup, 32 restoring-division stages
// (one quotient bit per stage, nine lanes sharing one divisor), and a final
// saturation stage that is also the output register. A new matrix is
// accepted every cycle while the output is not stalled, and without
// stalls the sustained rate is one matrix per clock. Each stage holds
// its item while the stage after it is full and stalled, so bubbles are
// squeezed out and input is taken while a finished result waits at the
// output.
module matrix_inverse_3x3_top
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  mi3_pkg::in_t     in_data,
    output logic             out_valid,
    input  logic             out_stall,
    output mi3_pkg::out_t    out_data
);

    localparam int NSTG  = 8 + mi3_pkg::QW;
    localparam int SDIV0 = 7;                 // first division stage
    localparam int NL    = mi3_pkg::NLANE;

    // Valid bits travel with the data; a stage loads when it is empty or
    // the stage after it is loading.
    logic [NSTG-1:0] vld_reg;
    logic [NSTG-1:0] vld_next;
    logic [NSTG-1:0] rdy;

    always_comb
    begin
        rdy[NSTG-1] = !vld_reg[NSTG-1] || !out_stall;
        for (int k = NSTG - 2; k >= 0; k--)
        begin
            rdy[k] = !vld_reg[k] || rdy[k + 1];
        end
        vld_next[0] = rdy[0] ? in_valid : vld_reg[0];
        for (int k = 1; k < NSTG; k++)
        begin
            vld_next[k] = rdy[k] ? vld_reg[k - 1] : vld_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    assign in_stall  = !rdy[0];
    assign out_valid = vld_reg[NSTG-1];

    // Stage 0: capture the elements.
    logic signed [mi3_pkg::EW-1:0] m_reg [NL];

    always_ff @(posedge clk)
    begin
        if (rdy[0] && in_valid)
        begin
            m_reg[0] <= in_data.m00;
            m_reg[1] <= in_data.m01;
            m_reg[2] <= in_data.m02;
            m_reg[3] <= in_data.m10;
            m_reg[4] <= in_data.m11;
            m_reg[5] <= in_data.m12;
            m_reg[6] <= in_data.m20;
            m_reg[7] <= in_data.m21;
            m_reg[8] <= in_data.m22;
        end
    end

    // Stage 1: the eighteen element products of the cofactors.
    logic signed [mi3_pkg::PW-1:0] pp_reg [NL];
    logic signed [mi3_pkg::PW-1:0] pq_reg [NL];
    logic signed [mi3_pkg::EW-1:0] abc1_reg [3];

    always_ff @(posedge clk)
    begin
        if (rdy[1] && vld_reg[0])
        begin
            for (int k = 0; k < NL; k++)
            begin
                pp_reg[k] <= mi3_pkg::PW'(m_reg[mi3_pkg::PA[k]])
                           * mi3_pkg::PW'(m_reg[mi3_pkg::PB[k]]);
                pq_reg[k] <= mi3_pkg::PW'(m_reg[mi3_pkg::QA[k]])
                           * mi3_pkg::PW'(m_reg[mi3_pkg::QB[k]]);
            end
            for (int j = 0; j < 3; j++)
            begin
                abc1_reg[j] <= m_reg[j];
            end
        end
    end

    // Stage 2: cofactors, which are also the adjugate elements.
    logic signed [mi3_pkg::AW-1:0] adj2_reg [NL];
    logic signed [mi3_pkg::EW-1:0] abc2_reg [3];

    always_ff @(posedge clk)
    begin
        if (rdy[2] && vld_reg[1])
        begin
            for (int k = 0; k < NL; k++)
            begin
                adj2_reg[k] <= mi3_pkg::AW'(pp_reg[k]) - mi3_pkg::AW'(pq_reg[k]);
            end
            abc2_reg <= abc1_reg;
        end
    end

    // Stage 3: first-row expansion products of the determinant.
    logic signed [mi3_pkg::DPW-1:0] dp_reg [3];
    logic signed [mi3_pkg::AW-1:0]  adj3_reg [NL];

    always_ff @(posedge clk)
    begin
        if (rdy[3] && vld_reg[2])
        begin
            for (int j = 0; j < 3; j++)
            begin
                dp_reg[j] <= mi3_pkg::DPW'(adj2_reg[3 * j])
                           * mi3_pkg::DPW'(abc2_reg[j]);
            end
            adj3_reg <= adj2_reg;
        end
    end

    // Stage 4: determinant.
    logic signed [mi3_pkg::DW-1:0] det_reg;
    logic signed [mi3_pkg::AW-1:0] adj4_reg [NL];

    always_ff @(posedge clk)
    begin
        if (rdy[4] && vld_reg[3])
        begin
            det_reg  <= mi3_pkg::DW'(dp_reg[0]) + mi3_pkg::DW'(dp_reg[1])
                      + mi3_pkg::DW'(dp_reg[2]);
            adj4_reg <= adj3_reg;
        end
    end

    // Stage 5: magnitudes, result signs and the rounded dividend
    // |adj| * 2^29 + |det|, to be divided by 2 * |det|.
    logic [mi3_pkg::ADW-1:0] adet5_reg;
    logic [mi3_pkg::NW-1:0]  num5_reg [NL];
    logic                    neg5_reg [NL];
    logic                    sng5_reg;
    logic [mi3_pkg::DW-1:0]  adet_full;

    assign adet_full = det_reg[mi3_pkg::DW-1] ? mi3_pkg::DW'(-det_reg)
                                              : mi3_pkg::DW'(det_reg);

    always_ff @(posedge clk)
    begin
        if (rdy[5] && vld_reg[4])
        begin
            for (int k = 0; k < NL; k++)
            begin
                num5_reg[k] <= (mi3_pkg::NW'(adj4_reg[k][mi3_pkg::AW-1]
                                ? mi3_pkg::AW'(-adj4_reg[k])
                                : mi3_pkg::AW'(adj4_reg[k])) << mi3_pkg::SH)
                             + mi3_pkg::NW'(adet_full[mi3_pkg::ADW-1:0]);
                neg5_reg[k] <= adj4_reg[k][mi3_pkg::AW-1] ^ det_reg[mi3_pkg::DW-1];
            end
            adet5_reg <= adet_full[mi3_pkg::ADW-1:0];
            sng5_reg  <= (det_reg == '0);
        end
    end

    // Stage 6 loads index 0 of the divider arrays; division stage s moves
    // index s to index s + 1. The quotient bits shift in at the bottom of
    // the word as the dividend bits shift out at the top.
    logic [mi3_pkg::DNW-1:0] rem_reg  [mi3_pkg::QW+1][NL];
    logic [mi3_pkg::QW-1:0]  word_reg [mi3_pkg::QW+1][NL];
    logic                    neg_reg  [mi3_pkg::QW+1][NL];
    logic                    ovf_reg  [mi3_pkg::QW+1][NL];
    logic [mi3_pkg::DNW-1:0] den_reg  [mi3_pkg::QW+1];
    logic                    sng_reg  [mi3_pkg::QW+1];

    logic [mi3_pkg::DNW-1:0] den6;
    assign den6 = {adet5_reg, 1'b0};

    always_ff @(posedge clk)
    begin
        if (rdy[6] && vld_reg[5])
        begin
            for (int k = 0; k < NL; k++)
            begin
                // A quotient of 2^32 or more is past either limit.
                ovf_reg[0][k]  <= mi3_pkg::DNW'(num5_reg[k][mi3_pkg::NW-1:mi3_pkg::QW])
                                  >= den6;
                rem_reg[0][k]  <= mi3_pkg::DNW'(num5_reg[k][mi3_pkg::NW-1:mi3_pkg::QW]);
                word_reg[0][k] <= num5_reg[k][mi3_pkg::QW-1:0];
                neg_reg[0][k]  <= neg5_reg[k];
            end
            den_reg[0] <= den6;
            sng_reg[0] <= sng5_reg;
        end
    end

    for (genvar s = 0; s < mi3_pkg::QW; s++)
    begin : g_div
        logic [mi3_pkg::DNW:0]   trial [NL];
        logic                    qbit  [NL];
        logic [mi3_pkg::DNW:0]   diff  [NL];

        always_comb
        begin
            for (int k = 0; k < NL; k++)
            begin
                trial[k] = {rem_reg[s][k], word_reg[s][k][mi3_pkg::QW-1]};
                diff[k]  = trial[k] - {1'b0, den_reg[s]};
                qbit[k]  = trial[k] >= {1'b0, den_reg[s]};
            end
        end

        always_ff @(posedge clk)
        begin
            if (rdy[SDIV0 + s] && vld_reg[SDIV0 + s - 1])
            begin
                for (int k = 0; k < NL; k++)
                begin
                    rem_reg[s + 1][k]  <= qbit[k] ? diff[k][mi3_pkg::DNW-1:0]
                                                  : trial[k][mi3_pkg::DNW-1:0];
                    word_reg[s + 1][k] <= {word_reg[s][k][mi3_pkg::QW-2:0], qbit[k]};
                    neg_reg[s + 1][k]  <= neg_reg[s][k];
                    ovf_reg[s + 1][k]  <= ovf_reg[s][k];
                end
                den_reg[s + 1] <= den_reg[s];
                sng_reg[s + 1] <= sng_reg[s];
            end
        end
    end

    // Final stage: saturate, apply the sign, and clear a singular result.
    logic [mi3_pkg::QW-1:0] res [NL];

    always_comb
    begin
        logic [mi3_pkg::QW:0] lim;
        logic [mi3_pkg::QW:0] mag;
        for (int k = 0; k < NL; k++)
        begin
            lim = neg_reg[mi3_pkg::QW][k] ? mi3_pkg::NEG_LIMIT : mi3_pkg::POS_LIMIT;
            mag = {1'b0, word_reg[mi3_pkg::QW][k]};
            if (ovf_reg[mi3_pkg::QW][k] || mag > lim)
            begin
                mag = lim;
            end
            if (sng_reg[mi3_pkg::QW])
            begin
                res[k] = '0;
            end
            else if (neg_reg[mi3_pkg::QW][k])
            begin
                res[k] = mi3_pkg::QW'(-mag);
            end
            else
            begin
                res[k] = mag[mi3_pkg::QW-1:0];
            end
        end
    end

    mi3_pkg::out_t out_reg;

    always_ff @(posedge clk)
    begin
        if (rdy[NSTG-1] && vld_reg[NSTG-2])
        begin
            out_reg.inv00    <= res[0];
            out_reg.inv01    <= res[1];
            out_reg.inv02    <= res[2];
            out_reg.inv10    <= res[3];
            out_reg.inv11    <= res[4];
            out_reg.inv12    <= res[5];
            out_reg.inv20    <= res[6];
            out_reg.inv21    <= res[7];
            out_reg.inv22    <= res[8];
            out_reg.singular <= sng_reg[mi3_pkg::QW];
        end
    end

    assign out_data = out_reg;

    // An empty input stage always takes a transfer.
    a_in_ready : assert property (@(posedge clk) disable iff (!rst_n)
        !vld_reg[0] |-> !in_stall)
        else $error("input stalled with an empty first stage");

    // A zero determinant gives a zero divisor, which the range check flags.
    a_sng_ovf : assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[6] && sng_reg[0] |-> ovf_reg[0][0])
        else $error("singular item not flagged as out of range");

    // Without overflow the starting remainder is below the divisor.
    a_rem_init : assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[6] && !ovf_reg[0][0] |-> rem_reg[0][0] < den_reg[0])
        else $error("division started with remainder not below divisor");

    // A singular result carries all-zero elements; the check samples the diagonal.
    a_sng_zero : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.singular |-> out_data.inv00 == '0
            && out_data.inv11 == '0 && out_data.inv22 == '0)
        else $error("singular result with nonzero elements");

endmodule
